### hw/rtl/dltq_pkg.sv
`default_nettype none

package dltq_pkg;

  // List geometry
  localparam int unsigned DEPTH = 16;
  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  // Field widths
  localparam int unsigned DELAY_W = 16;
  localparam int unsigned DEST_W  = 4;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned KIND_W  = 2;

  // Input opcodes
  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_EXPIRED = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } kind_e;

  // Controller to datapath
  typedef struct packed {
    logic  load;       // capture the input transaction
    logic  walk_step;  // subtract one delta, advance position
    logic  place;      // insert the new entry at the walk position
    logic  dec;        // decrement head delta
    logic  pop;        // drop head entry
    logic  out_load;   // load the result register
    kind_e out_kind;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic walk_more;   // walk must pass the current entry
    logic head_zero;   // head entry present and expired
    logic next_zero;   // second entry present and expires with the head
  } status_t;

endpackage

`default_nettype wire

### hw/rtl/dltq_ctrl.sv
`default_nettype none

module dltq_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic              opcode_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire dltq_pkg::status_t sts_i,
  output dltq_pkg::cmd_t         cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_WALK   = 6'b000010,
    ST_PLACE  = 6'b000100,
    ST_REJECT = 6'b001000,
    ST_DEC    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;
  logic   in_accept;

  // Result register can take a new result this cycle
  assign out_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.out_kind = dltq_pkg::KIND_EXPIRED;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          cmd_o.load = 1'b1;
          if (opcode_i == dltq_pkg::OP_INSERT) begin
            state_d = sts_i.full ? ST_REJECT : ST_WALK;
          end else begin
            state_d = sts_i.empty ? ST_IDLE : ST_DEC;
          end
        end
      end
      ST_WALK: begin
        cmd_o.walk_step = sts_i.walk_more;
        if (!sts_i.walk_more) begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (out_free) begin
          cmd_o.place    = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = dltq_pkg::KIND_ACCEPT;
          state_d        = ST_IDLE;
        end
      end
      ST_REJECT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = dltq_pkg::KIND_REJECT;
          state_d        = ST_IDLE;
        end
      end
      ST_DEC: begin
        cmd_o.dec = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.head_zero) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_kind = dltq_pkg::KIND_EXPIRED;
          cmd_o.pop      = 1'b1;
          if (!sts_i.next_zero) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_stall_i) begin
      out_valid_d = out_valid_q;
    end else begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dltq_dp.sv
`default_nettype none

module dltq_dp (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic [dltq_pkg::DELAY_W-1:0]          delay_i,
  input  wire logic [dltq_pkg::DEST_W-1:0]           dest_id_i,
  input  wire logic [dltq_pkg::TAG_W-1:0]            msg_tag_i,
  input  wire dltq_pkg::cmd_t                        cmd_i,
  output dltq_pkg::status_t                          sts_o,
  output logic [dltq_pkg::KIND_W-1:0]                kind_o,
  output logic [dltq_pkg::DEST_W-1:0]                out_dest_o,
  output logic [dltq_pkg::TAG_W-1:0]                 out_tag_o,
  output logic                                       last_o
);

  localparam int unsigned DEPTH   = dltq_pkg::DEPTH;
  localparam int unsigned IDX_W   = dltq_pkg::IDX_W;
  localparam int unsigned CNT_W   = dltq_pkg::CNT_W;
  localparam int unsigned DELAY_W = dltq_pkg::DELAY_W;
  localparam int unsigned DEST_W  = dltq_pkg::DEST_W;
  localparam int unsigned TAG_W   = dltq_pkg::TAG_W;

  // List cells
  logic [DELAY_W-1:0] delta_q [DEPTH];
  logic [DELAY_W-1:0] delta_d [DEPTH];
  logic [DEST_W-1:0]  edest_q [DEPTH];
  logic [DEST_W-1:0]  edest_d [DEPTH];
  logic [TAG_W-1:0]   etag_q  [DEPTH];
  logic [TAG_W-1:0]   etag_d  [DEPTH];
  logic [CNT_W-1:0]   count_q, count_d;

  // Working registers of the current transaction
  logic [DELAY_W-1:0] key_q, key_d;
  logic [IDX_W-1:0]   pos_q, pos_d;
  logic [DEST_W-1:0]  dest_q, dest_d;
  logic [TAG_W-1:0]   tag_q, tag_d;

  // Result register
  dltq_pkg::kind_e    kind_q, kind_d;
  logic [DEST_W-1:0]  odest_q, odest_d;
  logic [TAG_W-1:0]   otag_q, otag_d;
  logic               last_q, last_d;

  logic [DELAY_W-1:0] walk_delta;
  logic [DELAY_W-1:0] key_init;

  assign walk_delta = delta_q[pos_q];
  // Delivery on the (delay+1)-th tick, saturated at the field maximum
  assign key_init = (delay_i == '1) ? delay_i : delay_i + DELAY_W'(1);

  // Status
  assign sts_o.full      = (count_q == CNT_W'(DEPTH));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.walk_more = (CNT_W'(pos_q) < count_q) && (key_q >= walk_delta);
  assign sts_o.head_zero = (count_q != '0) && (delta_q[0] == '0);
  assign sts_o.next_zero = (count_q > CNT_W'(1)) && (delta_q[1] == '0);

  // Transaction capture and walk
  always_comb begin
    key_d  = key_q;
    pos_d  = pos_q;
    dest_d = dest_q;
    tag_d  = tag_q;
    if (cmd_i.load) begin
      key_d  = key_init;
      pos_d  = '0;
      dest_d = dest_id_i;
      tag_d  = msg_tag_i;
    end else if (cmd_i.walk_step) begin
      key_d = key_q - walk_delta;
      pos_d = pos_q + IDX_W'(1);
    end
  end

  // Cell updates: decrement head, pop head, or open a slot at pos_q
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      delta_d[i] = delta_q[i];
      edest_d[i] = edest_q[i];
      etag_d[i]  = etag_q[i];
      if (cmd_i.dec && i == 0) begin
        if (delta_q[0] != '0) begin
          delta_d[0] = delta_q[0] - DELAY_W'(1);
        end
      end else if (cmd_i.pop) begin
        if (i < DEPTH - 1) begin
          delta_d[i] = delta_q[i+1];
          edest_d[i] = edest_q[i+1];
          etag_d[i]  = etag_q[i+1];
        end
      end else if (cmd_i.place) begin
        if (IDX_W'(i) == pos_q) begin
          delta_d[i] = key_q;
          edest_d[i] = dest_q;
          etag_d[i]  = tag_q;
        end else if (i > 0 && IDX_W'(i) > pos_q) begin
          edest_d[i] = edest_q[i-1];
          etag_d[i]  = etag_q[i-1];
          // the entry right after the new one loses the new delta
          if (IDX_W'(i - 1) == pos_q) begin
            delta_d[i] = delta_q[i-1] - key_q;
          end else begin
            delta_d[i] = delta_q[i-1];
          end
        end
      end
    end
  end

  // Entry count
  always_comb begin
    count_d = count_q;
    if (cmd_i.place) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  // Result payload
  always_comb begin
    kind_d  = kind_q;
    odest_d = odest_q;
    otag_d  = otag_q;
    last_d  = last_q;
    if (cmd_i.out_load) begin
      kind_d = cmd_i.out_kind;
      if (cmd_i.out_kind == dltq_pkg::KIND_EXPIRED) begin
        odest_d = edest_q[0];
        otag_d  = etag_q[0];
        last_d  = !sts_o.next_zero;
      end else begin
        odest_d = dest_q;
        otag_d  = tag_q;
        last_d  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    pos_q   <= pos_d;
    dest_q  <= dest_d;
    tag_q   <= tag_d;
    kind_q  <= kind_d;
    odest_q <= odest_d;
    otag_q  <= otag_d;
    last_q  <= last_d;
    for (int i = 0; i < DEPTH; i++) begin
      delta_q[i] <= delta_d[i];
      edest_q[i] <= edest_d[i];
      etag_q[i]  <= etag_d[i];
    end
  end

  assign kind_o     = kind_q;
  assign out_dest_o = odest_q;
  assign out_tag_o  = otag_q;
  assign last_o     = last_q;

endmodule

`default_nettype wire

### hw/rtl/delta_list_timer_queue.sv
// Delta-list timer queue holding up to 16 delayed messages sorted by expiry,
// each stored as a delay relative to the entry before it. An accepted insert
// (opcode 1) walks the list one entry per cycle and then places the message.
// The walk passes at most the 15 entries already stored. An insert to a full
// list is rejected. Every insert answers with exactly one result: accepted or
// rejected. A message inserted with delay d is delivered on the (d+1)-th tick
// after it (on the d-th for the largest delay); equal expiries keep
// insertion order. A tick (opcode 0) decrements the head and then delivers
// every expired message in list order, one result per cycle while the
// output is not stalled, with last set on the final one. A tick that
// expires nothing gives no result, and a tick on an empty list leaves it
// unchanged. A new result waits while the output register still holds a
// stalled one. One input transaction is worked on at a time; a finished
// result may wait in the output register while the next transaction is
// accepted.
`default_nettype none

module delta_list_timer_queue (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              opcode_i,
  input  wire logic [dltq_pkg::DELAY_W-1:0]      delay_i,
  input  wire logic [dltq_pkg::DEST_W-1:0]       dest_id_i,
  input  wire logic [dltq_pkg::TAG_W-1:0]        msg_tag_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [dltq_pkg::KIND_W-1:0]            kind_o,
  output logic [dltq_pkg::DEST_W-1:0]            out_dest_o,
  output logic [dltq_pkg::TAG_W-1:0]             out_tag_o,
  output logic                                   last_o
);

  dltq_pkg::cmd_t    cmd;
  dltq_pkg::status_t sts;

  // Sequencer
  dltq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // List storage and result register
  dltq_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .delay_i    (delay_i),
    .dest_id_i  (dest_id_i),
    .msg_tag_i  (msg_tag_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .kind_o     (kind_o),
    .out_dest_o (out_dest_o),
    .out_tag_o  (out_tag_o),
    .last_o     (last_o)
  );

endmodule

`default_nettype wire
